/* rtl/core/tss_pkg.sv */
// Shared constants, types and codes for the three-sonar obstacle steering block.
package tss_pkg;

    localparam int COUNT_W    = 16;
    localparam int CM_W       = 11;
    localparam int SENSOR_W   = 2;
    localparam int NUM_SONARS = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int TRIG_TICKS_DEF     = 10;
    localparam int ECHO_COUNT_MAX_DEF = 65535;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_THR = 2'd1;

    localparam logic [CM_W-1:0] SIDE_THR_RST   = 11'd20;
    localparam logic [CM_W-1:0] CENTER_THR_RST = 11'd40;

    localparam logic [SENSOR_W-1:0] SONAR_LEFT   = 2'd0;
    localparam logic [SENSOR_W-1:0] SONAR_CENTER = 2'd1;
    localparam logic [SENSOR_W-1:0] SONAR_RIGHT  = 2'd2;

    // count / 58 == (count >> 1) / 29 == ((count >> 1) * 36158) >> 20, exact for 15-bit values
    localparam int CM_HALF_W  = COUNT_W - 1;
    localparam int CM_RECIP_W = 16;
    localparam int CM_PROD_W  = CM_HALF_W + CM_RECIP_W;
    localparam int CM_SHIFT   = 20;
    localparam logic [CM_RECIP_W-1:0] CM_RECIP = 16'd36158;

    // motor lines: bit 0 m1 fwd, bit 1 m1 back, bit 2 m2 fwd, bit 3 m2 back
    typedef logic [3:0] motor_t;
    localparam motor_t MOTOR_STOP       = 4'b0000;
    localparam motor_t MOTOR_TURN_RIGHT = 4'b0001;
    localparam motor_t MOTOR_TURN_LEFT  = 4'b0100;
    localparam motor_t MOTOR_FORWARD    = 4'b0101;

    typedef struct packed {
        logic [NUM_SONARS-1:0] trig;
        logic                  fin;
        logic [SENSOR_W-1:0]   sensor;
        logic [COUNT_W-1:0]    count;
    } meas_t;

endpackage

/* rtl/core/tss_if.sv */
// Handshake channels: echo words in, drive words out.
interface tss_echo_if;
    logic valid;
    logic ready;
    logic echo_left;
    logic echo_center;
    logic echo_right;

    modport source (output valid, output echo_left, output echo_center, output echo_right,
                    input ready);
    modport sink (input valid, input echo_left, input echo_center, input echo_right,
                  output ready);
endinterface

interface tss_drive_if import tss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                trig_left;
    logic                trig_center;
    logic                trig_right;
    logic                motor1_forward;
    logic                motor1_backward;
    logic                motor2_forward;
    logic                motor2_backward;
    logic                distance_ready;
    logic [SENSOR_W-1:0] distance_sensor;
    logic [CM_W-1:0]     distance_cm;

    modport source (output valid, output trig_left, output trig_center, output trig_right,
                    output motor1_forward, output motor1_backward, output motor2_forward,
                    output motor2_backward, output distance_ready, output distance_sensor,
                    output distance_cm, input ready);
    modport sink (input valid, input trig_left, input trig_center, input trig_right,
                  input motor1_forward, input motor1_backward, input motor2_forward,
                  input motor2_backward, input distance_ready, input distance_sensor,
                  input distance_cm, output ready);
endinterface

/* rtl/core/tss_ranger.sv */
// Sonar scan sequencer: trigger, wait for echo, count echo ticks, one sensor at a time.
module tss_ranger import tss_pkg::*;
#(
    parameter int TRIG_TICKS     = TRIG_TICKS_DEF,
    parameter int ECHO_COUNT_MAX = ECHO_COUNT_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [NUM_SONARS-1:0] echo,
    output meas_t                 meas
);

    localparam logic [1:0] PH_TRIG  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;

    localparam logic [COUNT_W-1:0] TRIG_LAST = COUNT_W'(TRIG_TICKS - 1);
    localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(ECHO_COUNT_MAX);

    logic [1:0]          phase_reg, phase_next;
    logic [SENSOR_W-1:0] sensor_reg, sensor_next;
    logic [COUNT_W-1:0]  tick_reg, tick_next;
    logic [SENSOR_W-1:0] idx;
    logic                echo_sel;

    always_comb
    begin
        idx = (sensor_reg > SONAR_RIGHT) ? SONAR_RIGHT : sensor_reg;
        unique case (idx)
            SONAR_LEFT:   echo_sel = echo[0];
            SONAR_CENTER: echo_sel = echo[1];
            default:      echo_sel = echo[2];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sensor_next = sensor_reg;
        tick_next   = tick_reg;
        meas.trig   = '0;
        meas.fin    = 1'b0;
        meas.sensor = idx;
        meas.count  = tick_reg;
        unique case (phase_reg)
            PH_WAIT:
            begin
                if (echo_sel)
                begin
                    phase_next = PH_COUNT;
                    tick_next  = COUNT_W'(1);
                end
            end
            PH_COUNT:
            begin
                if (echo_sel)
                begin
                    if (tick_reg < COUNT_TOP)
                        tick_next = tick_reg + COUNT_W'(1);
                end
                else
                begin
                    meas.fin    = 1'b1;
                    sensor_next = (idx == SONAR_RIGHT) ? SONAR_LEFT : idx + SENSOR_W'(1);
                    phase_next  = PH_TRIG;
                    tick_next   = '0;
                end
            end
            default:
            begin
                meas.trig[idx] = 1'b1;
                if (tick_reg >= TRIG_LAST)
                begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_reg + COUNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TRIG;
            sensor_reg <= SONAR_LEFT;
            tick_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            sensor_reg <= sensor_next;
            tick_reg   <= tick_next;
        end
    end

endmodule

/* rtl/core/tss_steer.sv */
// Keeps the last distance of each sonar and picks the motor drive after the right one.
module tss_steer import tss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                fin,
    input  logic [SENSOR_W-1:0] sensor,
    input  logic [CM_W-1:0]     cm,
    input  logic [CM_W-1:0]     side_thr,
    input  logic [CM_W-1:0]     center_thr,
    output motor_t              motor_next
);

    logic [CM_W-1:0] dist_reg [NUM_SONARS];
    logic [CM_W-1:0] dist_next [NUM_SONARS];
    motor_t          motor_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_SONARS; i++)
            dist_next[i] = (fin && sensor == SENSOR_W'(i)) ? cm : dist_reg[i];

        motor_next = motor_reg;
        if (fin && sensor == SONAR_RIGHT)
        begin
            priority if (dist_next[0] < side_thr)
                motor_next = MOTOR_TURN_RIGHT;
            else if (dist_next[2] < side_thr)
                motor_next = MOTOR_TURN_LEFT;
            else if (dist_next[1] < center_thr)
                motor_next = MOTOR_TURN_RIGHT;
            else
                motor_next = MOTOR_FORWARD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg <= MOTOR_STOP;
            for (int i = 0; i < NUM_SONARS; i++)
                dist_reg[i] <= '0;
        end
        else if (step)
        begin
            motor_reg <= motor_next;
            for (int i = 0; i < NUM_SONARS; i++)
                dist_reg[i] <= dist_next[i];
        end
    end

endmodule

/* rtl/core/three_sonar_obstacle_steering.sv */
// Top level of the three-sonar obstacle steering block.
//
//  channel  | dir | word                                        | accepted when
//  ---------+-----+---------------------------------------------+--------------------------
//  echo     | in  | echo_left, echo_center, echo_right          | echo.valid && echo.ready
//  drive    | out | trig x3, motor lines x4, distance_ready,    | drive.valid && drive.ready
//           |     | distance_sensor, distance_cm                |
//  cfg      | in  | cfg_index, cfg_data                         | cfg_we
//
// One echo word per cycle while the pipeline is not halted; its drive word passes through
// the sequencer register, divide-by-58 multiply register and steering/output register.
// The pipeline advances as a whole; it halts only while the output word waits on drive.ready.
// Reset: scan starts with the left trigger, distances zero, motors stopped,
// thresholds 20 cm side and 40 cm center.
module three_sonar_obstacle_steering import tss_pkg::*;
#(
    parameter int TRIG_TICKS     = TRIG_TICKS_DEF,
    parameter int ECHO_COUNT_MAX = ECHO_COUNT_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tss_echo_if.sink              echo,
    tss_drive_if.source           drive,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic            adv;
    logic            take;
    meas_t           meas;
    logic [CM_W-1:0] side_thr_reg, center_thr_reg;

    logic            s1_valid_reg;
    meas_t           s1_meas_reg;
    logic            s2_valid_reg;
    meas_t           s2_meas_reg;
    logic [CM_W-1:0] s2_cm_reg;
    logic [CM_PROD_W-1:0] prod;

    logic                  out_valid_reg;
    logic [NUM_SONARS-1:0] out_trig_reg;
    motor_t                out_motor_reg;
    logic                  out_ready_reg;
    logic [SENSOR_W-1:0]   out_sensor_reg;
    logic [CM_W-1:0]       out_cm_reg;
    motor_t                motor_next;

    assign adv        = !out_valid_reg || drive.ready;
    assign echo.ready = adv;
    assign take       = echo.valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_thr_reg   <= SIDE_THR_RST;
            center_thr_reg <= CENTER_THR_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SIDE_THR)
                side_thr_reg <= cfg_data;
            else if (cfg_index == CFG_CENTER_THR)
                center_thr_reg <= cfg_data;
        end
    end

    tss_ranger #(
        .TRIG_TICKS     (TRIG_TICKS),
        .ECHO_COUNT_MAX (ECHO_COUNT_MAX)
    ) u_ranger (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (take),
        .echo  ({echo.echo_right, echo.echo_center, echo.echo_left}),
        .meas  (meas)
    );

    // ticks / 58 by reciprocal multiply
    assign prod = s1_meas_reg.count[COUNT_W-1:1] * CM_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= take;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meas_reg    <= meas;
            s2_meas_reg    <= s1_meas_reg;
            s2_cm_reg      <= s1_meas_reg.fin ? prod[CM_SHIFT +: CM_W] : '0;
            out_trig_reg   <= s2_meas_reg.trig;
            out_motor_reg  <= motor_next;
            out_ready_reg  <= s2_meas_reg.fin;
            out_sensor_reg <= s2_meas_reg.fin ? s2_meas_reg.sensor : SONAR_LEFT;
            out_cm_reg     <= s2_cm_reg;
        end
    end

    tss_steer u_steer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s2_valid_reg && adv),
        .fin        (s2_meas_reg.fin),
        .sensor     (s2_meas_reg.sensor),
        .cm         (s2_cm_reg),
        .side_thr   (side_thr_reg),
        .center_thr (center_thr_reg),
        .motor_next (motor_next)
    );

    assign drive.valid           = out_valid_reg;
    assign drive.trig_left       = out_trig_reg[0];
    assign drive.trig_center     = out_trig_reg[1];
    assign drive.trig_right      = out_trig_reg[2];
    assign drive.motor1_forward  = out_motor_reg[0];
    assign drive.motor1_backward = out_motor_reg[1];
    assign drive.motor2_forward  = out_motor_reg[2];
    assign drive.motor2_backward = out_motor_reg[3];
    assign drive.distance_ready  = out_ready_reg;
    assign drive.distance_sensor = out_sensor_reg;
    assign drive.distance_cm     = out_cm_reg;

endmodule

/* rtl/core/tss_checker.sv */
// Port-level assertions for the three-sonar obstacle steering block, bound to the top level.
module tss_checker import tss_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                drive_valid,
    input logic                drive_ready,
    input logic [2:0]          trig,
    input logic [3:0]          motor,
    input logic                distance_ready,
    input logic [SENSOR_W-1:0] distance_sensor,
    input logic [CM_W-1:0]     distance_cm
);

    // a stalled word stays valid and holds trig, motor, distance_ready and distance_cm
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && !drive_ready) |=> (drive_valid && $stable(trig) && $stable(motor)
            && $stable(distance_ready) && $stable(distance_cm)))
        else $error("drive word changed while stalled");

    a_one_trig: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> $onehot0(trig))
        else $error("more than one trigger high");

    a_no_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> (!motor[1] && !motor[3]))
        else $error("backward motor line driven");

    a_idle_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && !distance_ready) |-> (distance_cm == '0 && distance_sensor == '0))
        else $error("distance fields set without a finished measurement");

    a_trig_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && distance_ready) |-> (trig == 3'b000 && distance_sensor != 2'd3))
        else $error("finished measurement during trigger or bad sensor code");

endmodule

bind three_sonar_obstacle_steering tss_checker u_tss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .drive_valid     (drive.valid),
    .drive_ready     (drive.ready),
    .trig            ({drive.trig_right, drive.trig_center, drive.trig_left}),
    .motor           ({drive.motor2_backward, drive.motor2_forward,
                       drive.motor1_backward, drive.motor1_forward}),
    .distance_ready  (drive.distance_ready),
    .distance_sensor (drive.distance_sensor),
    .distance_cm     (drive.distance_cm)
);

/* sim/three_sonar_obstacle_steering_test.sv */
// Self-checking testbench for the three-sonar obstacle steering block.
`timescale 1ns / 100ps

module three_sonar_obstacle_steering_test;
    import tss_pkg::*;

    localparam int LATENCY  = 3;
    localparam int CM_DIV   = 58;
    localparam int STEP_BUDGET = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {SCAN_TRIG, SCAN_WAIT, SCAN_COUNT} scan_phase_t;

    typedef struct packed {
        logic [NUM_SONARS-1:0] trig;
        motor_t                motor;
        logic                  done;
        logic [SENSOR_W-1:0]   sonar;
        logic [CM_W-1:0]       cm;
    } drive_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tss_echo_if  echo_bus ();
    tss_drive_if drive_bus ();

    three_sonar_obstacle_steering #(
        .TRIG_TICKS     (TRIG_TICKS_DEF),
        .ECHO_COUNT_MAX (ECHO_COUNT_MAX_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .echo      (echo_bus),
        .drive     (drive_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // echo words: bit 0 left, bit 1 center, bit 2 right
    logic [NUM_SONARS-1:0] echo_words[$];
    drive_word_t           expected_drive[$];
    int                    errors = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    logic [SENSOR_W-1:0]   gen_sonar = SONAR_LEFT;

    // predictor state
    scan_phase_t     scan_phase;
    logic [SENSOR_W-1:0] scan_sonar;
    int unsigned     tick_cnt;
    logic [CM_W-1:0] range_cm[NUM_SONARS];
    motor_t          motor_lines;
    logic [CM_W-1:0] side_thr   = SIDE_THR_RST;
    logic [CM_W-1:0] center_thr = CENTER_THR_RST;

    task automatic report(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [CM_W-1:0] got,
                               input logic [CM_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // one echo tick in, one drive word out
    task automatic range_and_steer(input logic [NUM_SONARS-1:0] echo);
        drive_word_t         w;
        logic [SENSOR_W-1:0] s;
        logic                hit;
        w = '0;
        s = scan_sonar;
        hit = echo[s];
        case (scan_phase)
            SCAN_WAIT:
            begin
                if (hit)
                begin
                    scan_phase = SCAN_COUNT;
                    tick_cnt = 1;
                end
            end
            SCAN_COUNT:
            begin
                if (hit)
                begin
                    if (tick_cnt < ECHO_COUNT_MAX_DEF)
                        tick_cnt++;
                end
                else
                begin
                    w.cm = CM_W'(tick_cnt / CM_DIV);
                    w.done = 1'b1;
                    w.sonar = s;
                    range_cm[s] = w.cm;
                    if (s == SONAR_RIGHT)
                    begin
                        if (range_cm[SONAR_LEFT] < side_thr)
                            motor_lines = MOTOR_TURN_RIGHT;
                        else if (range_cm[SONAR_RIGHT] < side_thr)
                            motor_lines = MOTOR_TURN_LEFT;
                        else if (range_cm[SONAR_CENTER] < center_thr)
                            motor_lines = MOTOR_TURN_RIGHT;
                        else
                            motor_lines = MOTOR_FORWARD;
                        scan_sonar = SONAR_LEFT;
                    end
                    else
                        scan_sonar = s + 1'b1;
                    scan_phase = SCAN_TRIG;
                    tick_cnt = 0;
                end
            end
            default:
            begin
                w.trig[s] = 1'b1;
                tick_cnt++;
                if (tick_cnt >= TRIG_TICKS_DEF)
                begin
                    scan_phase = SCAN_WAIT;
                    tick_cnt = 0;
                end
            end
        endcase
        w.motor = motor_lines;
        expected_drive.push_back(w);
    endtask

    // one sensor turn: trigger ticks, low wait, echo pulse, falling tick
    task automatic add_measurement(input int wait_len, input int high_len);
        logic [NUM_SONARS-1:0] w;
        for (int i = 0; i < TRIG_TICKS_DEF; i++)
            echo_words.push_back(NUM_SONARS'($urandom_range(0, 7)));
        for (int i = 0; i < wait_len; i++)
        begin
            w = NUM_SONARS'($urandom_range(0, 7));
            w[gen_sonar] = 1'b0;
            echo_words.push_back(w);
        end
        for (int i = 0; i < high_len; i++)
        begin
            w = NUM_SONARS'($urandom_range(0, 7));
            w[gen_sonar] = 1'b1;
            echo_words.push_back(w);
        end
        w = NUM_SONARS'($urandom_range(0, 7));
        w[gen_sonar] = 1'b0;
        echo_words.push_back(w);
        gen_sonar = (gen_sonar == SONAR_RIGHT) ? SONAR_LEFT : gen_sonar + 1'b1;
    endtask

    // mostly short pulses so the 0/1/2 cm boundaries get hit often
    task automatic add_random_steps(input int budget);
        int added;
        int wait_len;
        int high_len;
        added = 0;
        while (added < budget)
        begin
            wait_len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40)
                                                    : $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       high_len = $urandom_range(1, 8);
                1:       high_len = $urandom_range(CM_DIV - 2, CM_DIV + 1);
                2:       high_len = $urandom_range(2 * CM_DIV - 2, 2 * CM_DIV + 1);
                default: high_len = $urandom_range(1, CM_DIV);
            endcase
            add_measurement(wait_len, high_len);
            added += TRIG_TICKS_DEF + wait_len + high_len + 1;
        end
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SIDE_THR:   side_thr = value;
            CFG_CENTER_THR: center_thr = value;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (echo_words.size() != 0 || echo_bus.valid || expected_drive.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("three_sonar_obstacle_steering_test NOT OK");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_bus.valid       <= 1'b0;
            echo_bus.echo_left   <= 1'b0;
            echo_bus.echo_center <= 1'b0;
            echo_bus.echo_right  <= 1'b0;
        end
        else if (!echo_bus.valid || echo_bus.ready)
        begin
            if (echo_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin : feed
                logic [NUM_SONARS-1:0] w;
                w = echo_words.pop_front();
                echo_bus.valid       <= 1'b1;
                echo_bus.echo_left   <= w[SONAR_LEFT];
                echo_bus.echo_center <= w[SONAR_CENTER];
                echo_bus.echo_right  <= w[SONAR_RIGHT];
            end
            else
                echo_bus.valid <= 1'b0;
        end
    end

    // monitor: predict on each accepted echo word, check each accepted drive word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_bus.ready <= 1'b0;
            scan_phase  = SCAN_TRIG;
            scan_sonar  = SONAR_LEFT;
            tick_cnt    = 0;
            motor_lines = MOTOR_STOP;
            for (int i = 0; i < NUM_SONARS; i++)
                range_cm[i] = '0;
        end
        else
        begin
            if (echo_bus.valid && echo_bus.ready)
                range_and_steer({echo_bus.echo_right, echo_bus.echo_center,
                                 echo_bus.echo_left});
            if (drive_bus.valid && drive_bus.ready)
            begin
                if (expected_drive.size() == 0)
                    report("drive word with nothing expected");
                else
                begin : compare
                    drive_word_t e;
                    e = expected_drive.pop_front();
                    check_field("trig_left", CM_W'(drive_bus.trig_left),
                                CM_W'(e.trig[SONAR_LEFT]));
                    check_field("trig_center", CM_W'(drive_bus.trig_center),
                                CM_W'(e.trig[SONAR_CENTER]));
                    check_field("trig_right", CM_W'(drive_bus.trig_right),
                                CM_W'(e.trig[SONAR_RIGHT]));
                    check_field("motor1_forward", CM_W'(drive_bus.motor1_forward),
                                CM_W'(e.motor[0]));
                    check_field("motor1_backward", CM_W'(drive_bus.motor1_backward),
                                CM_W'(e.motor[1]));
                    check_field("motor2_forward", CM_W'(drive_bus.motor2_forward),
                                CM_W'(e.motor[2]));
                    check_field("motor2_backward", CM_W'(drive_bus.motor2_backward),
                                CM_W'(e.motor[3]));
                    check_field("distance_ready", CM_W'(drive_bus.distance_ready),
                                CM_W'(e.done));
                    check_field("distance_sensor", CM_W'(drive_bus.distance_sensor),
                                CM_W'(e.sonar));
                    check_field("distance_cm", drive_bus.distance_cm, e.cm);
                end
            end
            drive_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SIDE_THR;
        cfg_data             = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 88;
        // reset thresholds; left exactly 1 cm, center waits a while before a
        // one-tick echo, right just under 1 cm -> turn right
        add_measurement(0, CM_DIV);
        add_measurement(24, 1);
        add_measurement(1, CM_DIV - 1);
        settle();

        set_register(CFG_SIDE_THR, 11'd1);
        set_register(CFG_CENTER_THR, 11'd2);
        add_random_steps(STEP_BUDGET);
        settle();

        send_idle_pct = 88;
        recv_idle_pct = 34;
        set_register(CFG_SIDE_THR, 11'd0);
        set_register(CFG_CENTER_THR, 11'd0);
        add_random_steps(STEP_BUDGET);
        settle();

        set_register(CFG_SIDE_THR, 11'd1129);
        set_register(CFG_CENTER_THR, 11'd1129);
        add_random_steps(STEP_BUDGET);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_register(CFG_SIDE_THR, CFG_DATA_W'($urandom_range(1, 3)));
        set_register(CFG_CENTER_THR, CFG_DATA_W'($urandom_range(1, 3)));
        add_random_steps(STEP_BUDGET);
        settle();

        // spare index must not disturb either threshold
        set_register(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
        set_register(CFG_SIDE_THR, 11'd2);
        set_register(CFG_CENTER_THR, 11'd2047);
        add_random_steps(STEP_BUDGET);
        settle();

        if (errors == 0)
            $display("three_sonar_obstacle_steering_test OK");
        else
            $display("three_sonar_obstacle_steering_test NOT OK");
        $finish;
    end

endmodule
